### design/byte_diff_span_summarizer_defines.svh
// Assertion macros shared by the byte difference span summarizer modules
`ifndef BYTE_DIFF_SPAN_SUMMARIZER_DEFINES_SVH
`define BYTE_DIFF_SPAN_SUMMARIZER_DEFINES_SVH

// check cons in the same cycle as ante
`define BDSS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// check cons in the cycle after ante
`define BDSS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/bdss_pkg.sv
// Shared types and constants of the byte difference span summarizer
`default_nettype none

package bdss_pkg;

    localparam logic [63:0] FNV_BASIS = 64'hCBF2_9CE4_8422_2325;

    localparam logic REC_SPAN    = 1'b0;
    localparam logic REC_SUMMARY = 1'b1;

    typedef struct packed {
        logic        record_kind;
        logic [15:0] span_offset;
        logic [16:0] span_length;
        logic [63:0] before_digest;
        logic [63:0] after_digest;
        logic [16:0] changed_total;
        logic [4:0]  spans_kept;
        logic        spans_dropped;
        logic [16:0] block_length;
        logic        run_end;
    } bdss_rec_t;

    typedef struct packed {
        logic span;
        logic summary;
    } bdss_push_t;

endpackage

`default_nettype wire

### design/bdss_core.sv
// Digest, difference counting and span tracking for one byte pair per cycle in which fire is high
`default_nettype none
`include "byte_diff_span_summarizer_defines.svh"

module bdss_core
    import bdss_pkg::*;
#(
    parameter int MAX_SPANS       = 16,
    parameter int MAX_BLOCK_BYTES = 65536
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       fire,
    input  wire logic [7:0] before_byte,
    input  wire logic [7:0] after_byte,
    input  wire logic       final_pair,
    output bdss_push_t      push,
    output bdss_rec_t       span_rec,
    output bdss_rec_t       sum_rec
);

    localparam int POS_W = $clog2(MAX_BLOCK_BYTES + 1);
    localparam int SC_W  = $clog2(MAX_SPANS + 1);
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(MAX_BLOCK_BYTES - 1);
    localparam logic [SC_W-1:0]  MAX_SC   = SC_W'(MAX_SPANS);

    function automatic logic [63:0] fnv_step(input logic [63:0] acc, input logic [7:0] data);
        logic [63:0] x;
        x = acc ^ {56'd0, data};
        return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
    endfunction

    logic [63:0]      before_hash_reg;
    logic [63:0]      after_hash_reg;
    logic [POS_W-1:0] position_reg;
    logic [POS_W-1:0] changed_reg;
    logic [SC_W-1:0]  span_cnt_reg;
    logic             trunc_reg;
    logic             in_run_reg;
    logic [POS_W-1:0] run_start_reg;

    logic             diff;
    logic             last;
    logic             close_run;
    logic             room;
    logic             kept;
    logic [POS_W-1:0] here1;
    logic [POS_W-1:0] run_start_next;
    logic [POS_W-1:0] span_end;
    logic [POS_W-1:0] span_len;
    logic [POS_W-1:0] changed_next;
    logic [SC_W-1:0]  span_cnt_next;
    logic             trunc_next;
    logic [63:0]      before_hash_next;
    logic [63:0]      after_hash_next;
    logic [31:0]      start_w;
    logic [31:0]      len_w;
    logic [31:0]      changed_w;
    logic [31:0]      blk_w;
    logic [31:0]      sc_w;

    always_comb
    begin
        diff             = before_byte != after_byte;
        last             = final_pair || (position_reg == LAST_POS);
        close_run        = (in_run_reg && !diff) || (last && diff);
        room             = span_cnt_reg < MAX_SC;
        kept             = close_run && room;
        here1            = position_reg + POS_W'(1);
        run_start_next   = (diff && !in_run_reg) ? position_reg : run_start_reg;
        span_end         = diff ? here1 : position_reg;
        span_len         = span_end - run_start_next;
        changed_next     = changed_reg + POS_W'(diff);
        span_cnt_next    = span_cnt_reg + SC_W'(kept);
        trunc_next       = trunc_reg | (close_run & !room);
        before_hash_next = fnv_step(before_hash_reg, before_byte);
        after_hash_next  = fnv_step(after_hash_reg, after_byte);
        start_w          = 32'(run_start_next);
        len_w            = 32'(span_len);
        changed_w        = 32'(changed_next);
        blk_w            = 32'(here1);
        sc_w             = 32'(span_cnt_next);
    end

    always_comb
    begin
        push.span    = fire && kept;
        push.summary = fire && last;

        span_rec               = '0;
        span_rec.record_kind   = REC_SPAN;
        span_rec.span_offset   = start_w[15:0];
        span_rec.span_length   = len_w[16:0];
        span_rec.run_end       = !last;

        sum_rec                = '0;
        sum_rec.record_kind    = REC_SUMMARY;
        sum_rec.before_digest  = before_hash_next;
        sum_rec.after_digest   = after_hash_next;
        sum_rec.changed_total  = changed_w[16:0];
        sum_rec.spans_kept     = sc_w[4:0];
        sum_rec.spans_dropped  = trunc_next;
        sum_rec.block_length   = blk_w[16:0];
        sum_rec.run_end        = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            before_hash_reg <= FNV_BASIS;
            after_hash_reg  <= FNV_BASIS;
            position_reg    <= '0;
            changed_reg     <= '0;
            span_cnt_reg    <= '0;
            trunc_reg       <= 1'b0;
            in_run_reg      <= 1'b0;
            run_start_reg   <= '0;
        end
        else if (fire)
        begin
            if (last)
            begin
                before_hash_reg <= FNV_BASIS;
                after_hash_reg  <= FNV_BASIS;
                position_reg    <= '0;
                changed_reg     <= '0;
                span_cnt_reg    <= '0;
                trunc_reg       <= 1'b0;
                in_run_reg      <= 1'b0;
                run_start_reg   <= '0;
            end
            else
            begin
                before_hash_reg <= before_hash_next;
                after_hash_reg  <= after_hash_next;
                position_reg    <= here1;
                changed_reg     <= changed_next;
                span_cnt_reg    <= span_cnt_next;
                trunc_reg       <= trunc_next;
                in_run_reg      <= diff;
                run_start_reg   <= run_start_next;
            end
        end
    end

    `BDSS_ASSERT_NOW(a_span_cnt_bound, 1'b1, span_cnt_reg <= MAX_SC, "span count above capacity")
    `BDSS_ASSERT_NEXT(a_pos_advance, fire && !last, position_reg == $past(position_reg) + POS_W'(1), "position did not advance")
    `BDSS_ASSERT_NEXT(a_block_restart, fire && last, position_reg == '0 && !in_run_reg, "block state not cleared after last pair")

endmodule

`default_nettype wire

### design/bdss_out_fifo.sv
// Four-entry result queue that takes up to two records per cycle
`default_nettype none
`include "byte_diff_span_summarizer_defines.svh"

module bdss_out_fifo
    import bdss_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire bdss_push_t push,
    input  wire bdss_rec_t  span_rec,
    input  wire bdss_rec_t  sum_rec,
    output logic            room,
    output logic            out_valid,
    input  wire logic       out_ready,
    output bdss_rec_t       head
);

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    bdss_rec_t        mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [CNT_W-1:0] push_n;
    logic [PTR_W-1:0] sum_ptr;
    logic             pop;

    always_comb
    begin
        push_n     = CNT_W'(push.span) + CNT_W'(push.summary);
        pop        = out_valid && out_ready;
        count_next = count_reg + push_n - CNT_W'(pop);
        sum_ptr    = wr_ptr_reg + PTR_W'(push.span);
        room       = count_reg <= CNT_W'(DEPTH - 2);
        out_valid  = count_reg != '0;
        head       = mem[rd_ptr_reg];
    end

    always_ff @(posedge clk)
    begin
        if (push.span)
        begin
            mem[wr_ptr_reg] <= span_rec;
        end
        if (push.summary)
        begin
            mem[sum_ptr] <= sum_rec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + PTR_W'(push_n);
            rd_ptr_reg <= rd_ptr_reg + PTR_W'(pop);
            count_reg  <= count_next;
        end
    end

    `BDSS_ASSERT_NOW(a_no_overflow, push_n != '0, ({1'b0, count_reg} + {1'b0, push_n}) <= (CNT_W + 1)'(DEPTH), "result queue overflow")
    `BDSS_ASSERT_NOW(a_span_then_summary, push.span && push.summary, !span_rec.run_end && sum_rec.run_end, "span record must precede summary")
    `BDSS_ASSERT_NEXT(a_head_hold, out_valid && !out_ready, out_valid && $stable(head), "head record changed while waiting")

endmodule

`default_nettype wire

### design/byte_diff_span_summarizer.sv
// Top level of the byte difference span summarizer
//
// Takes one before/after byte pair per cycle while in_ready is high and keeps
// FNV-1a 64 digests of both streams, a count of differing positions and the runs
// of differing bytes. A span record leaves when a run closes (at most MAX_SPANS
// per block, later ones only set the dropped flag); the last pair of a block, or
// the pair at position MAX_BLOCK_BYTES-1, also yields a summary record, after which
// a new block starts. An accepted pair is held in the input register until the
// queue has room, then the digest and span logic writes its zero, one or two
// records into a four-entry result queue, from which records are presented in
// order. Pairs go in at one per cycle while the queue has two free entries; the
// output side moves one record per cycle while out_ready is high, so a pair that
// ends both a run and the block yields two records, and sustained input rate is
// then set by how fast records are taken.
`default_nettype none

module byte_diff_span_summarizer
    import bdss_pkg::*;
#(
    parameter int MAX_SPANS       = 16,
    parameter int MAX_BLOCK_BYTES = 65536
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  before_byte,
    input  wire logic [7:0]  after_byte,
    input  wire logic        final_pair,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             record_kind,
    output logic [15:0]      span_offset,
    output logic [16:0]      span_length,
    output logic [63:0]      before_digest,
    output logic [63:0]      after_digest,
    output logic [16:0]      changed_total,
    output logic [4:0]       spans_kept,
    output logic             spans_dropped,
    output logic [16:0]      block_length,
    output logic             run_end
);

    logic       s1_valid_reg;
    logic [7:0] s1_before_reg;
    logic [7:0] s1_after_reg;
    logic       s1_final_reg;
    logic       room;
    logic       fire;
    logic       in_take;
    bdss_push_t push;
    bdss_rec_t  span_rec;
    bdss_rec_t  sum_rec;
    bdss_rec_t  head;

    assign fire     = s1_valid_reg && room;
    assign in_ready = !s1_valid_reg || fire;
    assign in_take  = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (fire)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_before_reg <= before_byte;
            s1_after_reg  <= after_byte;
            s1_final_reg  <= final_pair;
        end
    end

    bdss_core #(
        .MAX_SPANS       (MAX_SPANS),
        .MAX_BLOCK_BYTES (MAX_BLOCK_BYTES)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (fire),
        .before_byte (s1_before_reg),
        .after_byte  (s1_after_reg),
        .final_pair  (s1_final_reg),
        .push        (push),
        .span_rec    (span_rec),
        .sum_rec     (sum_rec)
    );

    bdss_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .span_rec  (span_rec),
        .sum_rec   (sum_rec),
        .room      (room),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .head      (head)
    );

    assign record_kind   = head.record_kind;
    assign span_offset   = head.span_offset;
    assign span_length   = head.span_length;
    assign before_digest = head.before_digest;
    assign after_digest  = head.after_digest;
    assign changed_total = head.changed_total;
    assign spans_kept    = head.spans_kept;
    assign spans_dropped = head.spans_dropped;
    assign block_length  = head.block_length;
    assign run_end       = head.run_end;

endmodule

`default_nettype wire
